// ===== rtl/rbas_pkg.sv =====
// rbas_pkg: shared types, constants and the luma function of the byte alignment scorer
// depends on nothing; imported by every rbas_* module and the top level

package rbas_pkg;

	localparam int unsigned LUMA_W  = 11;
	localparam int unsigned DIFF_W  = 12;
	localparam int unsigned SUM_W   = 24;
	localparam logic [SUM_W-1:0] SUM_MAX = 24'hFF_FFFF;

	localparam logic [4:0] R_MASK = 5'h1F;
	localparam logic [5:0] G_MASK = 6'h3F;
	localparam logic [4:0] B_MASK = 5'h1F;
	localparam logic [LUMA_W-1:0] R_WEIGHT = 11'd10;
	localparam logic [LUMA_W-1:0] G_WEIGHT = 11'd20;
	localparam logic [LUMA_W-1:0] B_WEIGHT = 11'd4;

	// control of one byte entering the luma stage
	typedef struct packed {
		logic valid;
		logic odd;        // pixel belongs to the byte-one alignment
		logic set_left;   // grid column minus one: remember as left neighbor
		logic accum;      // grid point: add gradients
		logic wr_upper;   // grid row minus one: store as upper neighbor
		logic last;       // frame end byte
		logic is_short;   // frame ended before the last grid pixel
	} pix_ctl_t;

	// control of one byte entering the accumulate stage
	typedef struct packed {
		logic valid;
		logic odd;
		logic accum;
		logic last;
		logic is_short;
	} acc_ctl_t;

	// little-endian rgb565 word to weighted luma 10r + 20g + 4b
	function automatic logic [LUMA_W-1:0] luma_of(input logic [15:0] c);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = c[15:11] & R_MASK;
		g = c[10:5] & G_MASK;
		b = c[4:0] & B_MASK;
		return LUMA_W'(r) * R_WEIGHT + LUMA_W'(g) * G_WEIGHT + LUMA_W'(b) * B_WEIGHT;
	endfunction

endpackage

// ===== rtl/rbas_track.sv =====
// rbas_track: byte position, pixel coordinate counters and the input register stage
// depends on rbas_pkg

module rbas_track import rbas_pkg::*; #(
	parameter int FRAME_WIDTH  = 320,
	parameter int FRAME_HEIGHT = 240,
	parameter int SAMPLE_STEP  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                adv,
	input  logic [7:0]          pixel_byte,
	input  logic                frame_end,
	output logic [$clog2((FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP + 1)-1:0] rd_col,
	output pix_ctl_t            ctl_s1,
	output logic [15:0]         pix_s1,
	output logic [$clog2((FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP + 1)-1:0] col_s1
);

	localparam int unsigned FRAME_BYTES  = 2 * FRAME_WIDTH * FRAME_HEIGHT;
	localparam int unsigned POS_W        = $clog2(FRAME_BYTES + 1);
	localparam int unsigned LAST_X       = ((FRAME_WIDTH - 2) / SAMPLE_STEP) * SAMPLE_STEP + 1;
	localparam int unsigned LAST_Y       = ((FRAME_HEIGHT - 2) / SAMPLE_STEP) * SAMPLE_STEP + 1;
	localparam int unsigned BYTES_NEEDED = 2 * (LAST_Y * FRAME_WIDTH + LAST_X) + 3;
	localparam int unsigned UPPER_DEPTH  = (FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
	localparam int unsigned COL_W        = $clog2(UPPER_DEPTH + 1);
	localparam int unsigned X_W          = $clog2(FRAME_WIDTH);
	localparam int unsigned R_W          = $clog2(SAMPLE_STEP);
	localparam logic [X_W-1:0] X_LAST    = X_W'(FRAME_WIDTH - 1);
	localparam logic [R_W-1:0] R_LAST    = R_W'(SAMPLE_STEP - 1);
	localparam logic [R_W-1:0] R_ZERO    = '0;
	localparam logic [R_W-1:0] R_ONE     = R_W'(1);

	logic [POS_W-1:0] pos_q, pos_next;
	logic [7:0]       prev_q;
	logic [X_W-1:0]   x_q, x_d;
	logic [R_W-1:0]   xr_q, xr_d, yr_q, yr_d;
	logic [COL_W-1:0] col_q, col_d;
	logic             in_frame, take_even, take_odd, take;
	pix_ctl_t         ctl_d;

	assign in_frame  = pos_q < POS_W'(FRAME_BYTES);
	assign take_even = in_frame && pos_q[0];
	assign take_odd  = in_frame && !pos_q[0] && (pos_q != '0);
	assign take      = take_even || take_odd;
	assign pos_next  = in_frame ? pos_q + POS_W'(1) : pos_q;
	assign rd_col    = col_q;

	// next pixel coordinates, walked once per pixel after the odd alignment used it
	always_comb begin
		x_d   = x_q + X_W'(1);
		xr_d  = xr_q;
		yr_d  = yr_q;
		col_d = col_q;
		if (x_q == X_LAST) begin
			x_d   = '0;
			xr_d  = '0;
			col_d = '0;
			yr_d  = (yr_q == R_LAST) ? R_ZERO : yr_q + R_W'(1);
		end else if (xr_q == R_LAST) begin
			xr_d  = '0;
			col_d = col_q + COL_W'(1);
		end else begin
			xr_d  = xr_q + R_W'(1);
		end
	end

	always_comb begin
		ctl_d.valid    = 1'b1;
		ctl_d.odd      = take_odd;
		ctl_d.set_left = take && (yr_q == R_ONE) && (xr_q == R_ZERO);
		ctl_d.accum    = take && (yr_q == R_ONE) && (xr_q == R_ONE);
		ctl_d.wr_upper = take && (yr_q == R_ZERO) && (xr_q == R_ONE);
		ctl_d.last     = frame_end;
		ctl_d.is_short = 32'(pos_next) < BYTES_NEEDED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
			x_q    <= '0;
			xr_q   <= '0;
			yr_q   <= '0;
			col_q  <= '0;
			ctl_s1 <= '0;
		end else begin
			if (accept) begin
				if (in_frame) begin
					prev_q <= pixel_byte;
				end
				if (frame_end) begin
					pos_q <= '0;
					x_q   <= '0;
					xr_q  <= '0;
					yr_q  <= '0;
					col_q <= '0;
				end else begin
					pos_q <= pos_next;
					if (take_odd) begin
						x_q   <= x_d;
						xr_q  <= xr_d;
						yr_q  <= yr_d;
						col_q <= col_d;
					end
				end
			end
			if (adv) begin
				ctl_s1 <= accept ? ctl_d : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= {pixel_byte, prev_q};
			col_s1 <= col_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(FRAME_BYTES))
		else $error("byte position ran past the frame size");
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> pos_q == '0 && col_q == '0)
		else $error("position not cleared after frame end");
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl_d.set_left, ctl_d.accum, ctl_d.wr_upper}))
		else $error("more than one grid action for one byte");
`endif

endmodule

// ===== rtl/rbas_upper.sv =====
// rbas_upper: upper neighbor luma stores, one per alignment, registered read
// depends on rbas_pkg

module rbas_upper import rbas_pkg::*; #(
	parameter int FRAME_WIDTH = 320,
	parameter int SAMPLE_STEP = 4
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [$clog2((FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP + 1)-1:0] rd_col,
	input  logic                wr_en,
	input  logic                wr_odd,
	input  logic [$clog2((FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP + 1)-1:0] wr_col,
	input  logic [LUMA_W-1:0]   wr_luma,
	output logic [LUMA_W-1:0]   up_even_s1,
	output logic [LUMA_W-1:0]   up_odd_s1
);

	localparam int unsigned UPPER_DEPTH = (FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;

	logic [LUMA_W-1:0] mem_even [UPPER_DEPTH];
	logic [LUMA_W-1:0] mem_odd  [UPPER_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en && !wr_odd) begin
			mem_even[wr_col] <= wr_luma;
		end
		if (wr_en && wr_odd) begin
			mem_odd[wr_col] <= wr_luma;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_even_s1 <= mem_even[rd_col];
			up_odd_s1  <= mem_odd[rd_col];
		end
	end

endmodule

// ===== rtl/rbas_grad.sv =====
// rbas_grad: luma of the registered pixel, left neighbors and gradient magnitude stage
// depends on rbas_pkg

module rbas_grad import rbas_pkg::*; #(
	parameter int FRAME_WIDTH = 320,
	parameter int SAMPLE_STEP = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  pix_ctl_t            ctl_s1,
	input  logic [15:0]         pix_s1,
	input  logic [$clog2((FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP + 1)-1:0] col_s1,
	input  logic [LUMA_W-1:0]   up_even_s1,
	input  logic [LUMA_W-1:0]   up_odd_s1,
	output logic                wr_en,
	output logic                wr_odd,
	output logic [$clog2((FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP + 1)-1:0] wr_col,
	output logic [LUMA_W-1:0]   wr_luma,
	output acc_ctl_t            ctl_s2,
	output logic [DIFF_W-1:0]   diff_s2
);

	logic [LUMA_W-1:0] luma, left_sel, up_sel, left_even_q, left_odd_q;
	logic [LUMA_W-1:0] d_left, d_up;
	logic              step;

	assign step     = adv && ctl_s1.valid;
	assign luma     = luma_of(pix_s1);
	assign left_sel = ctl_s1.odd ? left_odd_q : left_even_q;
	assign up_sel   = ctl_s1.odd ? up_odd_s1 : up_even_s1;
	assign d_left   = (luma > left_sel) ? luma - left_sel : left_sel - luma;
	assign d_up     = (luma > up_sel) ? luma - up_sel : up_sel - luma;

	assign wr_en   = step && ctl_s1.wr_upper;
	assign wr_odd  = ctl_s1.odd;
	assign wr_col  = col_s1;
	assign wr_luma = luma;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_even_q <= '0;
			left_odd_q  <= '0;
			ctl_s2      <= '0;
		end else begin
			if (step && ctl_s1.set_left && !ctl_s1.odd) begin
				left_even_q <= luma;
			end
			if (step && ctl_s1.set_left && ctl_s1.odd) begin
				left_odd_q <= luma;
			end
			if (adv) begin
				ctl_s2.valid    <= ctl_s1.valid;
				ctl_s2.odd      <= ctl_s1.odd;
				ctl_s2.accum    <= ctl_s1.accum;
				ctl_s2.last     <= ctl_s1.last;
				ctl_s2.is_short <= ctl_s1.is_short;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s2 <= DIFF_W'(d_left) + DIFF_W'(d_up);
		end
	end

endmodule

// ===== rtl/rbas_accum.sv =====
// rbas_accum: saturating gradient sums per alignment and the result register
// depends on rbas_pkg

module rbas_accum import rbas_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  acc_ctl_t            ctl_s2,
	input  logic [DIFF_W-1:0]   diff_s2,
	input  logic                score_stall,
	output logic                adv,
	output logic                busy,
	output logic                score_valid,
	output logic [SUM_W-1:0]    score_even,
	output logic [SUM_W-1:0]    score_odd,
	output logic                pick_odd,
	output logic                frame_short
);

	logic [SUM_W-1:0]  sum_even_q, sum_odd_q, sat_even, sat_odd;
	logic [SUM_W:0]    wide_even, wide_odd;
	logic [DIFF_W-1:0] add_even, add_odd;
	logic              step, close;

	// a pending frame result with a full result register blocks the pipe while score_stall is high
	assign busy  = ctl_s2.valid && ctl_s2.last && score_valid;
	assign adv   = !(busy && score_stall);
	assign step  = adv && ctl_s2.valid;
	assign close = step && ctl_s2.last;

	assign add_even  = (ctl_s2.accum && !ctl_s2.odd) ? diff_s2 : '0;
	assign add_odd   = (ctl_s2.accum && ctl_s2.odd) ? diff_s2 : '0;
	assign wide_even = {1'b0, sum_even_q} + (SUM_W + 1)'(add_even);
	assign wide_odd  = {1'b0, sum_odd_q} + (SUM_W + 1)'(add_odd);
	assign sat_even  = wide_even[SUM_W] ? SUM_MAX : wide_even[SUM_W-1:0];
	assign sat_odd   = wide_odd[SUM_W] ? SUM_MAX : wide_odd[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_even_q  <= '0;
			sum_odd_q   <= '0;
			score_valid <= 1'b0;
		end else begin
			if (close) begin
				sum_even_q  <= '0;
				sum_odd_q   <= '0;
			end else if (step) begin
				sum_even_q  <= sat_even;
				sum_odd_q   <= sat_odd;
			end
			if (close) begin
				score_valid <= 1'b1;
			end else if (!score_stall) begin
				score_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			score_even  <= sat_even;
			score_odd   <= sat_odd;
			pick_odd    <= sat_odd > sat_even;
			frame_short <= ctl_s2.is_short;
		end
	end

`ifndef NO_ASSERTIONS
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		close |=> sum_even_q == '0 && sum_odd_q == '0)
		else $error("sums not cleared after frame result");
	a_no_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!score_valid |-> adv)
		else $error("pipe held with an empty result register");
	a_pick_matches: assert property (@(posedge clk) disable iff (!arst_n)
		close |=> pick_odd == (score_odd > score_even))
		else $error("alignment pick disagrees with the sums");
`endif

endmodule

// ===== rtl/rgb565_byte_alignment_scorer_top.sv =====
// rgb565_byte_alignment_scorer_top: top level of the rgb565 byte alignment scorer
// depends on rbas_pkg, rbas_track, rbas_upper, rbas_grad, rbas_accum
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------------
//  byte     | in        | byte_valid / byte_stall | pixel_byte, frame_end
//  score    | out       | score_valid/score_stall | score_even, score_odd, pick_odd,
//           |           |                         | frame_short
//
// one byte per cycle is taken while byte_stall is low; a byte passes an input register
// stage, a luma and gradient stage and an accumulate stage, and the frame result is
// registered in the result register when its frame end byte leaves the accumulate stage
// the upper neighbor store is read when a byte is transferred, written from the luma stage
// reset clears positions, left neighbors and sums; the upper stores need no clearing
// byte_stall rises while a frame result sits in the accumulate stage and the result
// register still holds the previous one

module rgb565_byte_alignment_scorer_top import rbas_pkg::*; #(
	parameter int FRAME_WIDTH  = 320,
	parameter int FRAME_HEIGHT = 240,
	parameter int SAMPLE_STEP  = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [7:0]       pixel_byte,
	input  logic             frame_end,
	output logic             score_valid,
	input  logic             score_stall,
	output logic [SUM_W-1:0] score_even,
	output logic [SUM_W-1:0] score_odd,
	output logic             pick_odd,
	output logic             frame_short
);

	localparam int unsigned UPPER_DEPTH = (FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
	localparam int unsigned COL_W       = $clog2(UPPER_DEPTH + 1);

	logic              accept, adv, busy;
	// input register stage
	pix_ctl_t          ctl_s1;
	logic [15:0]       pix_s1;
	logic [COL_W-1:0]  col_s1, rd_col;
	logic [LUMA_W-1:0] up_even_s1, up_odd_s1;
	// upper store write from the luma stage
	logic              wr_en, wr_odd;
	logic [COL_W-1:0]  wr_col;
	logic [LUMA_W-1:0] wr_luma;
	// accumulate stage
	acc_ctl_t          ctl_s2;
	logic [DIFF_W-1:0] diff_s2;

	// stall comes from registered state only, never from score_stall directly
	assign byte_stall = busy;
	assign accept     = byte_valid && !byte_stall;

	rbas_track #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT),
		.SAMPLE_STEP (SAMPLE_STEP)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.adv       (adv),
		.pixel_byte(pixel_byte),
		.frame_end (frame_end),
		.rd_col    (rd_col),
		.ctl_s1    (ctl_s1),
		.pix_s1    (pix_s1),
		.col_s1    (col_s1)
	);

	// read at the transfer so the upper neighbor lines up with the input register
	rbas_upper #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.SAMPLE_STEP(SAMPLE_STEP)
	) u_upper (
		.clk       (clk),
		.rd_en     (accept),
		.rd_col    (rd_col),
		.wr_en     (wr_en),
		.wr_odd    (wr_odd),
		.wr_col    (wr_col),
		.wr_luma   (wr_luma),
		.up_even_s1(up_even_s1),
		.up_odd_s1 (up_odd_s1)
	);

	rbas_grad #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.SAMPLE_STEP(SAMPLE_STEP)
	) u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s1    (ctl_s1),
		.pix_s1    (pix_s1),
		.col_s1    (col_s1),
		.up_even_s1(up_even_s1),
		.up_odd_s1 (up_odd_s1),
		.wr_en     (wr_en),
		.wr_odd    (wr_odd),
		.wr_col    (wr_col),
		.wr_luma   (wr_luma),
		.ctl_s2    (ctl_s2),
		.diff_s2   (diff_s2)
	);

	// sums and the result register; holds the pipe only behind a waiting result
	rbas_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s2     (ctl_s2),
		.diff_s2    (diff_s2),
		.score_stall(score_stall),
		.adv        (adv),
		.busy       (busy),
		.score_valid(score_valid),
		.score_even (score_even),
		.score_odd  (score_odd),
		.pick_odd   (pick_odd),
		.frame_short(frame_short)
	);

endmodule

// ===== test/rgb565_byte_alignment_scorer_top_tb.sv =====
// rgb565_byte_alignment_scorer_top_tb: self-checking bench that streams camera frames byte by
// byte into the alignment scorer and predicts both gradient sums, the pick and the short flag
// depends on rbas_pkg and rgb565_byte_alignment_scorer_top

module rgb565_byte_alignment_scorer_top_tb;
	import rbas_pkg::*;

	// geometry under test, the one the block is used with
	localparam int unsigned FRAME_WIDTH  = 320;
	localparam int unsigned FRAME_HEIGHT = 240;
	localparam int unsigned SAMPLE_STEP  = 4;

	localparam int unsigned FRAME_BYTES = FRAME_WIDTH * FRAME_HEIGHT * 2;
	localparam int unsigned GRID_COLS   = (FRAME_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
	localparam int unsigned LAST_GX     = ((FRAME_WIDTH - 2) / SAMPLE_STEP) * SAMPLE_STEP + 1;
	localparam int unsigned LAST_GY     = ((FRAME_HEIGHT - 2) / SAMPLE_STEP) * SAMPLE_STEP + 1;
	// the odd alignment needs one byte more than the even one for its last grid pixel
	localparam int unsigned BYTES_NEEDED = 2 * (LAST_GY * FRAME_WIDTH + LAST_GX) + 3;

	localparam int unsigned LONG_HOLD    = 60;   // receiver hold-off right after reset
	localparam int unsigned SETTLE_CYCLES = 8;   // pipeline is three stages deep
	localparam int unsigned RANDOM_FRAMES = 12;
	// long frame: the whole upper neighbor row plus a stretch of the first grid row
	localparam int unsigned GRID_FRAME_BYTES = 2 * (FRAME_WIDTH + 40);

	typedef enum {FILL_NOISE, FILL_FLAT, FILL_BW} fill_t;

	typedef struct {
		logic [7:0]  value;
		logic        last;
		int unsigned lead;        // idle cycles before the byte is offered
		bit          drain_first; // hold the byte back until no frame result is open
	} cam_byte_t;

	typedef struct packed {
		logic [SUM_W-1:0] even_sum;
		logic [SUM_W-1:0] odd_sum;
		logic             odd_wins;
		logic             cut_short;
	} frame_score_t;

	// clock, reset and dut ports; the driven inputs are known from time zero
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             byte_valid = 1'b0;
	logic             byte_stall;
	logic [7:0]       pixel_byte = '0;
	logic             frame_end = 1'b0;
	logic             score_valid;
	logic             score_stall = 1'b1;
	logic [SUM_W-1:0] score_even;
	logic [SUM_W-1:0] score_odd;
	logic             pick_odd;
	logic             frame_short;

	// stimulus and expected frame results
	cam_byte_t    pending_bytes[$];
	frame_score_t expected_scores[$];
	cam_byte_t    head_byte;
	frame_score_t seen_score;

	// predictor state; neighbors and sums are kept once per alignment
	int unsigned stream_pos;
	logic [7:0]  last_byte;
	int unsigned left_even;
	int unsigned left_odd;
	int unsigned upper_even[GRID_COLS];
	int unsigned upper_odd[GRID_COLS];
	int unsigned energy_even;
	int unsigned energy_odd;

	// bookkeeping
	int unsigned bytes_total;
	int unsigned bytes_sent;
	int unsigned results_checked;
	int unsigned stall_cycles;
	int unsigned lead_left;
	bit          lead_loaded;
	int unsigned rx_long;
	int unsigned rx_wait;
	bit          score_taken;
	bit          any_fail;

	rgb565_byte_alignment_scorer_top #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT),
		.SAMPLE_STEP (SAMPLE_STEP)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.pixel_byte (pixel_byte),
		.frame_end  (frame_end),
		.score_valid(score_valid),
		.score_stall(score_stall),
		.score_even (score_even),
		.score_odd  (score_odd),
		.pick_odd   (pick_odd),
		.frame_short(frame_short)
	);

	initial forever #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	// one rgb565 pixel of either alignment; k is its pixel index within the frame
	function automatic void grade_pixel(input bit odd_side, input int unsigned k,
			input logic [15:0] w);
		int unsigned x, y, col, lum, left_l, up_l, d, total;
		x = k % FRAME_WIDTH;
		y = k / FRAME_WIDTH;
		col = x / SAMPLE_STEP;
		lum = 10 * w[15:11] + 20 * w[10:5] + 4 * w[4:0];
		if (y % SAMPLE_STEP == 0) begin
			// row above a grid row: remember the upper neighbor
			if (x % SAMPLE_STEP == 1) begin
				if (odd_side)
					upper_odd[col] = lum;
				else
					upper_even[col] = lum;
			end
		end else if (y % SAMPLE_STEP == 1) begin
			if (x % SAMPLE_STEP == 0) begin
				if (odd_side)
					left_odd = lum;
				else
					left_even = lum;
			end else if (x % SAMPLE_STEP == 1) begin
				left_l = odd_side ? left_odd : left_even;
				up_l = odd_side ? upper_odd[col] : upper_even[col];
				d = abs_gap(lum, left_l) + abs_gap(lum, up_l);
				total = (odd_side ? energy_odd : energy_even) + d;
				if (total > SUM_MAX)
					total = SUM_MAX;
				if (odd_side)
					energy_odd = total;
				else
					energy_even = total;
			end
		end
	endfunction

	// advances the frame by one transferred byte, queues the frame result on frame end
	function automatic void advance_scores(input logic [7:0] b, input logic last);
		frame_score_t fs;
		if (stream_pos < FRAME_BYTES) begin
			if (stream_pos % 2 == 1)
				grade_pixel(1'b0, (stream_pos - 1) / 2, {b, last_byte});
			else if (stream_pos >= 2)
				grade_pixel(1'b1, (stream_pos - 2) / 2, {b, last_byte});
			last_byte = b;
			stream_pos++;
		end
		if (last) begin
			fs.even_sum = energy_even[SUM_W-1:0];
			fs.odd_sum = energy_odd[SUM_W-1:0];
			fs.odd_wins = energy_odd > energy_even;
			fs.cut_short = stream_pos < BYTES_NEEDED;
			expected_scores.push_back(fs);
			stream_pos = 0;
			energy_even = 0;
			energy_odd = 0;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic void queue_byte(input logic [7:0] v, input logic last,
			input int unsigned lead, input bit drain_first);
		cam_byte_t cb;
		cb.value = v;
		cb.last = last;
		cb.lead = lead;
		cb.drain_first = drain_first;
		pending_bytes.push_back(cb);
		bytes_total++;
	endfunction

	function automatic void queue_frame(input int unsigned len, input fill_t style,
			input int unsigned lead_cap, input bit drain_first);
		logic [15:0] flat;
		logic [7:0]  v;
		flat = $urandom;
		for (int unsigned i = 0; i < len; i++) begin
			case (style)
				FILL_FLAT: v = (i % 2 == 1) ? flat[15:8] : flat[7:0];
				FILL_BW:   v = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
				default:   v = $urandom;
			endcase
			queue_byte(v, i == len - 1, $urandom_range(0, lead_cap), drain_first && i == 0);
		end
	endfunction

	// ---------------------------------------------------------------- driver

	// offers the next camera byte; a stalled byte stays put, and the predictor runs on
	// every transfer so expectations line up with the order bytes went in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			pixel_byte <= '0;
			frame_end <= 1'b0;
			lead_left = 0;
			lead_loaded = 1'b0;
		end else begin
			if (byte_valid && byte_stall)
				stall_cycles++;
			if (byte_valid && !byte_stall) begin
				advance_scores(pixel_byte, frame_end);
				bytes_sent++;
			end
			if (!byte_valid || !byte_stall) begin
				if (pending_bytes.size() != 0 && !lead_loaded) begin
					lead_left = pending_bytes[0].lead;
					lead_loaded = 1'b1;
				end
				if (pending_bytes.size() == 0 || lead_left != 0 ||
						(pending_bytes[0].drain_first && expected_scores.size() != 0)) begin
					if (lead_left != 0)
						lead_left--;
					byte_valid <= 1'b0;
				end else begin
					head_byte = pending_bytes.pop_front();
					pixel_byte <= head_byte.value;
					frame_end <= head_byte.last;
					byte_valid <= 1'b1;
					lead_loaded = 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// takes frame results and checks them against the oldest expectation; after reset it
	// holds off for a long stretch so that back-to-back frame ends back up into the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_stall <= 1'b1;
			rx_long = LONG_HOLD;
			rx_wait = 0;
		end else begin
			score_taken = score_valid && !score_stall;
			if (score_taken) begin
				if (expected_scores.size() == 0) begin
					$error("score transfer with no frame result pending");
					any_fail = 1'b1;
				end else begin
					seen_score = expected_scores.pop_front();
					if (score_even !== seen_score.even_sum) begin
						$error("score_even: expected %0d, got %0d", seen_score.even_sum,
							score_even);
						any_fail = 1'b1;
					end
					if (score_odd !== seen_score.odd_sum) begin
						$error("score_odd: expected %0d, got %0d", seen_score.odd_sum,
							score_odd);
						any_fail = 1'b1;
					end
					if (pick_odd !== seen_score.odd_wins) begin
						$error("pick_odd: expected %0d, got %0d", seen_score.odd_wins, pick_odd);
						any_fail = 1'b1;
					end
					if (frame_short !== seen_score.cut_short) begin
						$error("frame_short: expected %0d, got %0d", seen_score.cut_short,
							frame_short);
						any_fail = 1'b1;
					end
				end
				results_checked++;
			end
			if (rx_long != 0) begin
				rx_long--;
				score_stall <= 1'b1;
			end else if (score_taken) begin
				// every 16 results a quiet run without stalls
				rx_wait = (results_checked % 16 < 4) ? 0 : $urandom_range(0, 3);
				score_stall <= (rx_wait != 0);
			end else if (score_valid && rx_wait != 0) begin
				rx_wait--;
				score_stall <= (rx_wait != 0);
			end else begin
				score_stall <= (rx_wait != 0);
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int unsigned len;
		int unsigned lead_cap;
		fill_t       style;

		for (int unsigned c = 0; c < GRID_COLS; c++) begin
			upper_even[c] = 0;
			upper_odd[c] = 0;
		end

		// single byte frames back to back while the receiver holds off: results pile up
		// and the block has to stall its input; byte values sweep the extremes
		for (int unsigned i = 0; i < 12; i++)
			queue_byte(8'(i * 8'h55), 1'b1, 0, 1'b0);
		// frames ending on the first even and the first odd pixel
		queue_byte(8'hFF, 1'b0, 0, 1'b0);
		queue_byte(8'hFF, 1'b1, 1, 1'b0);
		queue_byte(8'h00, 1'b0, 0, 1'b0);
		queue_byte(8'hFF, 1'b0, 2, 1'b0);
		queue_byte(8'h80, 1'b1, 0, 1'b0);

		// sender pauses for all open results, then one frame with no idling that runs
		// through the upper row and into the first grid row of both alignments
		queue_frame(GRID_FRAME_BYTES, FILL_NOISE, 0, 1'b1);

		// short random frames of mixed content and idling
		for (int unsigned f = 0; f < RANDOM_FRAMES; f++) begin
			len = $urandom_range(1, 50);
			case ($urandom_range(0, 5))
				0:       style = FILL_FLAT;
				1:       style = FILL_BW;
				default: style = FILL_NOISE;
			endcase
			lead_cap = ($urandom_range(0, 3) == 0) ? 0 : 3;
			queue_frame(len, style, lead_cap, 1'b0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_sent < bytes_total)
			@(posedge clk);
		while (expected_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("streamed %0d bytes and checked %0d frame results, short frames and grid rows",
			bytes_sent, results_checked);
		$display("input was held off for %0d cycles while results backed up", stall_cycles);
		if (!any_fail)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hard limit, several times the slowest legal run
	initial begin
		#500_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
